// File: rtl/core/ps2tx_pkg.sv
// shared types, constants and register map of the ps2 host transmitter
package ps2tx_pkg;

   localparam int PS2TX_COUNTER_WIDTH = 16;
   localparam int REG_W = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int FRAME_W = 10;
   localparam int BIT_IDX_W = 4;
   localparam int STATUS_W = 3;
   localparam logic [BIT_IDX_W-1:0] FRAME_BITS = 4'd10;

   localparam logic [REG_W-1:0] INHIBIT_RESET = 16'd120;
   localparam logic [REG_W-1:0] DATA_LOW_RESET = 16'd10;
   localparam logic [REG_W-1:0] RELEASE_RESET = 16'd10;
   localparam logic [REG_W-1:0] START_TIMEOUT_RESET = 16'd5000;
   localparam logic [REG_W-1:0] STEP_TIMEOUT_RESET = 16'd1000;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_START   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LOW_TO     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_HIGH_TO    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_ACK     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NO_RELEASE = 3'd5;

   typedef enum logic [2:0] {
      REG_INHIBIT_TICKS  = 3'd0,
      REG_DATA_LOW_TICKS = 3'd1,
      REG_RELEASE_TICKS  = 3'd2,
      REG_START_TIMEOUT  = 3'd3,
      REG_STEP_TIMEOUT   = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [REG_W-1:0] inhibit_ticks;
      logic [REG_W-1:0] data_low_ticks;
      logic [REG_W-1:0] release_ticks;
      logic [REG_W-1:0] start_timeout;
      logic [REG_W-1:0] step_timeout;
   } limits_type;

   typedef struct packed {
      logic                clk_drive_low;
      logic                data_drive_low;
      logic                busy_res;
      logic                done_res;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

// File: rtl/core/ps2_host_transmitter.sv
// top level of the ps2 host-to-device transmitter
// One request is one microsecond tick: the sampled ps2 clock and data line
// levels plus an optional start command with the byte to send (a start
// command while a send is in progress is ignored). Every request gives
// exactly one response with the line drives, busy, done and the status of
// the last finished send.
// Requests are taken into an input register, go through the sequencer in one
// pass and land in the response register; one request is taken every cycle
// while the receiver does not stall.
// When the receiver stalls, the response register holds, the input register
// fills and req_stall rises, so no request is lost.
// Reset clears both pipeline valids, puts the sequencer in idle with status
// ok and loads the timing registers with their default values. The timing
// registers are written over the csr port in the access phase, after setup.
module ps2_host_transmitter
   import ps2tx_pkg::*;
#(
   parameter int COUNTER_WIDTH = PS2TX_COUNTER_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [7:0]            req_tx_byte,
   input  logic                  req_clk_level,
   input  logic                  req_data_level,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_clk_drive_low,
   output logic                  rsp_data_drive_low,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic [STATUS_W-1:0]   rsp_status,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic       in_valid_ff, in_valid_in;
   logic       command_ff;
   logic [7:0] tx_byte_ff;
   logic       clk_level_ff;
   logic       data_level_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type result;
   limits_type limits;
   logic       advance;
   logic       step;
   logic       accept;

   ps2tx_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .limits      (limits)
   );

   ps2tx_fsm #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .command    (command_ff),
      .tx_byte    (tx_byte_ff),
      .clk_level  (clk_level_ff),
      .data_level (data_level_ff),
      .limits     (limits),
      .result     (result)
   );

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign step = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (advance) rsp_valid_in = in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         command_ff <= req_command;
         tx_byte_ff <= req_tx_byte;
         clk_level_ff <= req_clk_level;
         data_level_ff <= req_data_level;
      end
      if (step) rsp_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_clk_drive_low = rsp_ff.clk_drive_low;
   assign rsp_data_drive_low = rsp_ff.data_drive_low;
   assign rsp_busy_res = rsp_ff.busy_res;
   assign rsp_done_res = rsp_ff.done_res;
   assign rsp_status = rsp_ff.status;

endmodule

// File: rtl/core/ps2tx_csr.sv
// configuration registers of the ps2 host transmitter
module ps2tx_csr
   import ps2tx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output limits_type            limits
);

   logic [REG_W-1:0] inhibit_ff;
   logic [REG_W-1:0] data_low_ff;
   logic [REG_W-1:0] release_ff;
   logic [REG_W-1:0] start_to_ff;
   logic [REG_W-1:0] step_to_ff;
   logic             write_en;
   reg_index_type    index;
   logic [REG_W-1:0] wdata;
   logic [REG_W-1:0] rdata;

   assign write_en = csr_psel && csr_penable && csr_pwrite;
   assign index = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wdata = csr_pwdata[REG_W-1:0];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inhibit_ff <= INHIBIT_RESET;
         data_low_ff <= DATA_LOW_RESET;
         release_ff <= RELEASE_RESET;
         start_to_ff <= START_TIMEOUT_RESET;
         step_to_ff <= STEP_TIMEOUT_RESET;
      end else if (write_en) begin
         case (index)
            REG_INHIBIT_TICKS: inhibit_ff <= wdata;
            REG_DATA_LOW_TICKS: data_low_ff <= wdata;
            REG_RELEASE_TICKS: release_ff <= wdata;
            REG_START_TIMEOUT: start_to_ff <= wdata;
            REG_STEP_TIMEOUT: step_to_ff <= wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_INHIBIT_TICKS: rdata = inhibit_ff;
         REG_DATA_LOW_TICKS: rdata = data_low_ff;
         REG_RELEASE_TICKS: rdata = release_ff;
         REG_START_TIMEOUT: rdata = start_to_ff;
         REG_STEP_TIMEOUT: rdata = step_to_ff;
         default: rdata = '0;
      endcase
   end

   assign csr_prdata = CSR_DATA_W'(rdata);

   assign limits.inhibit_ticks = inhibit_ff;
   assign limits.data_low_ticks = data_low_ff;
   assign limits.release_ticks = release_ff;
   assign limits.start_timeout = start_to_ff;
   assign limits.step_timeout = step_to_ff;

endmodule

// File: rtl/core/ps2tx_fsm.sv
// send sequencer: phase, tick counter, frame and line drive per request
module ps2tx_fsm
   import ps2tx_pkg::*;
#(
   parameter int COUNTER_WIDTH = PS2TX_COUNTER_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       command,
   input  logic [7:0] tx_byte,
   input  logic       clk_level,
   input  logic       data_level,
   input  limits_type limits,
   output result_type result
);

   localparam int LIM_W = (COUNTER_WIDTH > REG_W) ? COUNTER_WIDTH : REG_W;
   localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

   typedef enum logic [8:0] {
      PH_IDLE       = 9'b000000001,
      PH_INHIBIT    = 9'b000000010,
      PH_DATA_LOW   = 9'b000000100,
      PH_RELEASE    = 9'b000001000,
      PH_WAIT_START = 9'b000010000,
      PH_WAIT_LOW   = 9'b000100000,
      PH_WAIT_HIGH  = 9'b001000000,
      PH_WAIT_ACK   = 9'b010000000,
      PH_WAIT_REL   = 9'b100000000
   } phase_type;

   function automatic logic [COUNTER_WIDTH-1:0] clamp(input logic [REG_W-1:0] v);
      logic [LIM_W-1:0] wide;
      wide = LIM_W'(v);
      if (wide > LIM_W'(CNT_MAX)) wide = LIM_W'(CNT_MAX);
      if (wide == '0) wide = LIM_W'(1);
      return COUNTER_WIDTH'(wide);
   endfunction

   phase_type                phase_ff, phase_in;
   logic [COUNTER_WIDTH-1:0] cnt_ff, cnt_in;
   logic [FRAME_W-1:0]       frame_ff, frame_in;
   logic [BIT_IDX_W-1:0]     bit_ff, bit_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic [REG_W-1:0]         raw_limit;
   logic [COUNTER_WIDTH-1:0] cur_limit;
   logic [COUNTER_WIDTH-1:0] cnt_inc;
   logic                     reached;
   logic                     done;
   logic [BIT_IDX_W-1:0]     bit_sel;
   logic                     cdrv;
   logic                     ddrv;

   always_comb begin
      case (phase_ff)
         PH_INHIBIT: raw_limit = limits.inhibit_ticks;
         PH_DATA_LOW: raw_limit = limits.data_low_ticks;
         PH_RELEASE: raw_limit = limits.release_ticks;
         PH_WAIT_START: raw_limit = limits.start_timeout;
         default: raw_limit = limits.step_timeout;
      endcase
   end

   assign cur_limit = clamp(raw_limit);
   assign cnt_inc = cnt_ff + COUNTER_WIDTH'(1);
   assign reached = (cnt_inc >= cur_limit);

   always_comb begin
      phase_in = phase_ff;
      cnt_in = cnt_ff;
      frame_in = frame_ff;
      bit_in = bit_ff;
      status_in = status_ff;
      done = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (command) begin
               frame_in = {1'b1, ~^tx_byte, tx_byte};
               bit_in = '0;
               phase_in = PH_INHIBIT;
               cnt_in = '0;
            end
         end
         PH_INHIBIT: begin
            if (reached) begin
               phase_in = PH_DATA_LOW;
               cnt_in = '0;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_DATA_LOW: begin
            if (reached) begin
               phase_in = PH_RELEASE;
               cnt_in = '0;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_RELEASE: begin
            if (reached) begin
               phase_in = PH_WAIT_START;
               cnt_in = '0;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_WAIT_START: begin
            if (!clk_level) begin
               bit_in = '0;
               phase_in = PH_WAIT_HIGH;
               cnt_in = '0;
            end else if (reached) begin
               status_in = ST_NO_START;
               done = 1'b1;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_WAIT_LOW: begin
            if (!clk_level) begin
               bit_in = bit_ff + BIT_IDX_W'(1);
               phase_in = PH_WAIT_HIGH;
               cnt_in = '0;
            end else if (reached) begin
               status_in = ST_LOW_TO;
               done = 1'b1;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_WAIT_HIGH: begin
            if (clk_level) begin
               phase_in = (bit_ff >= FRAME_BITS) ? PH_WAIT_ACK : PH_WAIT_LOW;
               cnt_in = '0;
            end else if (reached) begin
               status_in = ST_HIGH_TO;
               done = 1'b1;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_WAIT_ACK: begin
            if (!data_level) begin
               phase_in = PH_WAIT_REL;
               cnt_in = '0;
            end else if (reached) begin
               status_in = ST_NO_ACK;
               done = 1'b1;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_WAIT_REL: begin
            if (data_level) begin
               status_in = ST_OK;
               done = 1'b1;
            end else if (reached) begin
               status_in = ST_NO_RELEASE;
               done = 1'b1;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            cnt_in = '0;
            bit_in = '0;
         end
      endcase
      if (done) begin
         phase_in = PH_IDLE;
         cnt_in = '0;
         bit_in = '0;
      end
   end

   assign bit_sel = bit_in - BIT_IDX_W'(1);

   always_comb begin
      cdrv = 1'b0;
      ddrv = 1'b0;
      case (phase_in)
         PH_INHIBIT: cdrv = 1'b1;
         PH_DATA_LOW: begin
            cdrv = 1'b1;
            ddrv = 1'b1;
         end
         PH_RELEASE, PH_WAIT_START: ddrv = 1'b1;
         PH_WAIT_LOW, PH_WAIT_HIGH: begin
            if (bit_in == '0) ddrv = 1'b1;
            else if (bit_in <= FRAME_BITS) ddrv = ~frame_in[bit_sel];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff <= '0;
         frame_ff <= '0;
         bit_ff <= '0;
         status_ff <= ST_OK;
      end else if (step) begin
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
         frame_ff <= frame_in;
         bit_ff <= bit_in;
         status_ff <= status_in;
      end
   end

   assign result.clk_drive_low = cdrv;
   assign result.data_drive_low = ddrv;
   assign result.busy_res = (phase_in != PH_IDLE);
   assign result.done_res = done;
   assign result.status = status_in;

`ifndef NO_ASSERTIONS
   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      bit_ff <= FRAME_BITS)
      else $error("bit index past stop bit");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (cnt_ff == '0 && bit_ff == '0))
      else $error("idle with stale counter or bit index");

   a_start: assert property (@(posedge clock) disable iff (reset)
      (step && phase_ff == PH_IDLE && command) |=> (phase_ff == PH_INHIBIT))
      else $error("start request did not enter inhibit");

   a_release_ok: assert property (@(posedge clock) disable iff (reset)
      (step && phase_ff == PH_WAIT_REL && data_level)
      |=> (phase_ff == PH_IDLE && status_ff == ST_OK))
      else $error("data release did not finish with ok status");
`endif

endmodule
